[design/rsrc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rsrc_pkg;

    // Field widths
    localparam int MV_W    = 15;   // signed millivolt readings
    localparam int SUP_W   = 14;   // supply magnitude once the supply check has passed
    localparam int FRAC_W  = 16;   // Q0.16 fractions
    localparam int ABS_W   = 16;   // magnitude of a pair-sum deviation
    localparam int PROD_W  = SUP_W + FRAC_W;
    localparam int NUM_W   = 32;   // signed mapping numerator
    localparam int QUO_W   = 17;   // quotient bits of N * 2^17 / D
    localparam int RATIO_W = 16;
    localparam int CODE_W  = 3;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 16;
    localparam int S_DATA_W = 96;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 24;

    // Register indexes on the configuration port
    localparam logic [IDX_W-1:0] REG_STEER_LOW  = 3'd0;
    localparam logic [IDX_W-1:0] REG_STEER_HIGH = 3'd1;
    localparam logic [IDX_W-1:0] REG_PEDAL_LOW  = 3'd2;
    localparam logic [IDX_W-1:0] REG_PEDAL_HIGH = 3'd3;
    localparam logic [IDX_W-1:0] REG_SUM_TOL    = 3'd4;
    localparam logic [IDX_W-1:0] REG_SUP_FLOOR  = 3'd5;

    // Register reset values
    localparam logic [FRAC_W-1:0] RST_STEER_LOW  = 16'd9830;
    localparam logic [FRAC_W-1:0] RST_STEER_HIGH = 16'd55706;
    localparam logic [FRAC_W-1:0] RST_PEDAL_LOW  = 16'd15073;
    localparam logic [FRAC_W-1:0] RST_PEDAL_HIGH = 16'd50463;
    localparam logic [FRAC_W-1:0] RST_SUM_TOL    = 16'd9830;
    localparam logic [SUP_W-1:0]  RST_SUP_FLOOR  = 14'd100;

    // Saturation values of the Q1.15 ratio
    localparam logic [RATIO_W-1:0] RATIO_MIN  = 16'h8000;
    localparam logic [RATIO_W-1:0] RATIO_MAX  = 16'h7FFF;
    localparam logic [RATIO_W-1:0] RATIO_ZERO = 16'h0000;

    typedef enum logic [CODE_W-1:0] {
        FAULT_NONE   = 3'd0,
        FAULT_READ   = 3'd1,
        FAULT_SUPPLY = 3'd2,
        FAULT_MASTER = 3'd3,
        FAULT_SLAVE  = 3'd4,
        FAULT_LIMITS = 3'd5
    } fault_t;

    typedef struct packed {
        logic [FRAC_W-1:0] steer_low;
        logic [FRAC_W-1:0] steer_high;
        logic [FRAC_W-1:0] pedal_low;
        logic [FRAC_W-1:0] pedal_high;
        logic [FRAC_W-1:0] sum_tol;
        logic [SUP_W-1:0]  sup_floor;
    } cfg_regs_t;

    typedef struct packed {
        logic                    cmd;
        logic                    read_failed;
        logic signed [MV_W-1:0]  master_a_mv;
        logic signed [MV_W-1:0]  master_b_mv;
        logic signed [MV_W-1:0]  slave_a_mv;
        logic signed [MV_W-1:0]  slave_b_mv;
        logic signed [MV_W-1:0]  master_supply_mv;
        logic signed [MV_W-1:0]  slave_supply_mv;
    } in_item_t;

    // One word in flight through the divider
    typedef struct packed {
        fault_t              fault;
        logic                force_lo;
        logic                force_hi;
        logic [PROD_W-1:0]   rem;
        logic [PROD_W-1:0]   den;
        logic [QUO_W-1:0]    quo;
    } div_item_t;

endpackage

`default_nettype wire

[design/rsrc_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none

module rsrc_cfg
    import rsrc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              wr_en,
    input  wire logic [IDX_W-1:0]  wr_index,
    input  wire logic [CFG_W-1:0]  wr_data,
    output cfg_regs_t              regs
);

    cfg_regs_t regs_reg;

    // Register file; writes to unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg.steer_low  <= RST_STEER_LOW;
            regs_reg.steer_high <= RST_STEER_HIGH;
            regs_reg.pedal_low  <= RST_PEDAL_LOW;
            regs_reg.pedal_high <= RST_PEDAL_HIGH;
            regs_reg.sum_tol    <= RST_SUM_TOL;
            regs_reg.sup_floor  <= RST_SUP_FLOOR;
        end else if (wr_en) begin
            case (wr_index)
                REG_STEER_LOW:  regs_reg.steer_low  <= wr_data;
                REG_STEER_HIGH: regs_reg.steer_high <= wr_data;
                REG_PEDAL_LOW:  regs_reg.pedal_low  <= wr_data;
                REG_PEDAL_HIGH: regs_reg.pedal_high <= wr_data;
                REG_SUM_TOL:    regs_reg.sum_tol    <= wr_data;
                REG_SUP_FLOOR:  regs_reg.sup_floor  <= wr_data[SUP_W-1:0];
                default: ;
            endcase
        end
    end

    assign regs = regs_reg;

endmodule

`default_nettype wire

[design/rsrc_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module rsrc_front
    import rsrc_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      adv,
    input  wire logic      in_valid,
    input  in_item_t       in_item,
    input  cfg_regs_t      cfg,
    output logic           out_valid,
    output div_item_t      out_item
);

    // ---------------- Stage 1: limit select, supply test, pair deviations
    logic                     s1_valid_reg;
    logic                     s1_failed_reg;
    logic                     s1_sup_bad_reg;
    logic [ABS_W-1:0]         s1_abs_dm_reg;
    logic [ABS_W-1:0]         s1_abs_ds_reg;
    logic signed [MV_W-1:0]   s1_ma_reg;
    logic [SUP_W-1:0]         s1_ms_reg;
    logic [SUP_W-1:0]         s1_ss_reg;
    logic [FRAC_W-1:0]        s1_lo_reg;
    logic [FRAC_W-1:0]        s1_diff_reg;
    logic                     s1_bad_lim_reg;

    logic [FRAC_W-1:0]        lo_next;
    logic [FRAC_W-1:0]        hi_next;
    logic [MV_W+1:0]          dm_next;
    logic [MV_W+1:0]          ds_next;
    logic [ABS_W-1:0]         abs_dm_next;
    logic [ABS_W-1:0]         abs_ds_next;
    logic signed [MV_W-1:0]   floor_s;
    logic                     sup_bad_next;

    always_comb begin
        lo_next = in_item.cmd ? cfg.pedal_low  : cfg.steer_low;
        hi_next = in_item.cmd ? cfg.pedal_high : cfg.steer_high;
        // Pair sum minus supply, sign-extended to 17 bits.
        dm_next = {{2{in_item.master_a_mv[MV_W-1]}}, in_item.master_a_mv}
                + {{2{in_item.master_b_mv[MV_W-1]}}, in_item.master_b_mv}
                - {{2{in_item.master_supply_mv[MV_W-1]}}, in_item.master_supply_mv};
        ds_next = {{2{in_item.slave_a_mv[MV_W-1]}}, in_item.slave_a_mv}
                + {{2{in_item.slave_b_mv[MV_W-1]}}, in_item.slave_b_mv}
                - {{2{in_item.slave_supply_mv[MV_W-1]}}, in_item.slave_supply_mv};
        abs_dm_next = dm_next[MV_W+1] ? ABS_W'(-dm_next) : dm_next[ABS_W-1:0];
        abs_ds_next = ds_next[MV_W+1] ? ABS_W'(-ds_next) : ds_next[ABS_W-1:0];
        floor_s = $signed({1'b0, cfg.sup_floor});
        sup_bad_next = (in_item.master_supply_mv < floor_s)
                    || (in_item.slave_supply_mv < floor_s)
                    || (in_item.master_supply_mv == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_failed_reg  <= in_item.read_failed;
            s1_sup_bad_reg <= sup_bad_next;
            s1_abs_dm_reg  <= abs_dm_next;
            s1_abs_ds_reg  <= abs_ds_next;
            s1_ma_reg      <= in_item.master_a_mv;
            // Both supplies are non-negative and below 2^14 whenever they matter.
            s1_ms_reg      <= in_item.master_supply_mv[SUP_W-1:0];
            s1_ss_reg      <= in_item.slave_supply_mv[SUP_W-1:0];
            s1_lo_reg      <= lo_next;
            s1_diff_reg    <= hi_next - lo_next;
            s1_bad_lim_reg <= (hi_next <= lo_next);
        end
    end

    // ---------------- Stage 2: tolerance bounds and mapping products
    logic                     s2_valid_reg;
    logic                     s2_failed_reg;
    logic                     s2_sup_bad_reg;
    logic [ABS_W-1:0]         s2_abs_dm_reg;
    logic [ABS_W-1:0]         s2_abs_ds_reg;
    logic signed [MV_W-1:0]   s2_ma_reg;
    logic                     s2_bad_lim_reg;
    logic [PROD_W-1:0]        s2_tol_m_reg;
    logic [PROD_W-1:0]        s2_tol_s_reg;
    logic [PROD_W-1:0]        s2_off_reg;
    logic [PROD_W-1:0]        s2_den_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_failed_reg  <= s1_failed_reg;
            s2_sup_bad_reg <= s1_sup_bad_reg;
            s2_abs_dm_reg  <= s1_abs_dm_reg;
            s2_abs_ds_reg  <= s1_abs_ds_reg;
            s2_ma_reg      <= s1_ma_reg;
            s2_bad_lim_reg <= s1_bad_lim_reg;
            s2_tol_m_reg   <= {{FRAC_W{1'b0}}, s1_ms_reg} * {{SUP_W{1'b0}}, cfg.sum_tol};
            s2_tol_s_reg   <= {{FRAC_W{1'b0}}, s1_ss_reg} * {{SUP_W{1'b0}}, cfg.sum_tol};
            s2_off_reg     <= {{FRAC_W{1'b0}}, s1_ms_reg} * {{SUP_W{1'b0}}, s1_lo_reg};
            s2_den_reg     <= {{FRAC_W{1'b0}}, s1_ms_reg} * {{SUP_W{1'b0}}, s1_diff_reg};
        end
    end

    // ---------------- Stage 3: pair tests, fault priority, numerator
    logic                 s3_valid_reg;
    fault_t               s3_fault_reg;
    logic [NUM_W-1:0]     s3_num_reg;
    logic [PROD_W-1:0]    s3_den_reg;

    logic                 m_bad_next;
    logic                 s_bad_next;
    fault_t               fault_next;
    logic [NUM_W-1:0]     num_next;

    always_comb begin
        // |deviation| * 2^16 against supply * tolerance
        m_bad_next = {s2_abs_dm_reg, {FRAC_W{1'b0}}} > {2'b00, s2_tol_m_reg};
        s_bad_next = {s2_abs_ds_reg, {FRAC_W{1'b0}}} > {2'b00, s2_tol_s_reg};
        if (s2_failed_reg) begin
            fault_next = FAULT_READ;
        end else if (s2_sup_bad_reg) begin
            fault_next = FAULT_SUPPLY;
        end else if (m_bad_next) begin
            fault_next = FAULT_MASTER;
        end else if (s_bad_next) begin
            fault_next = FAULT_SLAVE;
        end else if (s2_bad_lim_reg) begin
            fault_next = FAULT_LIMITS;
        end else begin
            fault_next = FAULT_NONE;
        end
        num_next = {s2_ma_reg[MV_W-1], s2_ma_reg, {FRAC_W{1'b0}}} - {2'b00, s2_off_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (adv) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_fault_reg <= fault_next;
            s3_num_reg   <= num_next;
            s3_den_reg   <= s2_den_reg;
        end
    end

    // ---------------- Stage 4: saturation cases and divider set-up
    logic       s4_valid_reg;
    div_item_t  s4_item_reg;
    div_item_t  item_next;

    always_comb begin
        item_next.fault    = s3_fault_reg;
        item_next.force_lo = s3_num_reg[NUM_W-1] || (s3_num_reg == '0);
        item_next.force_hi = !s3_num_reg[NUM_W-1]
                          && (s3_num_reg[NUM_W-2:0] >= {1'b0, s3_den_reg});
        // Only used when 0 < N < D, where N fits the remainder width.
        item_next.rem      = s3_num_reg[PROD_W-1:0];
        item_next.den      = s3_den_reg;
        item_next.quo      = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else if (adv) begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_item_reg <= item_next;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_item  = s4_item_reg;

endmodule

`default_nettype wire

[design/rsrc_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module rsrc_div
    import rsrc_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   adv,
    input  wire logic   in_valid,
    input  div_item_t   in_item,
    output logic        out_valid,
    output div_item_t   out_item
);

    // One restoring step: shift the remainder and subtract the divisor if it fits.
    function automatic div_item_t div_step(input div_item_t cur);
        div_item_t        nxt;
        logic [PROD_W:0]  shifted;
        logic             fits;
        nxt     = cur;
        shifted = {cur.rem, 1'b0};
        fits    = shifted >= {1'b0, cur.den};
        nxt.rem = fits ? PROD_W'(shifted - {1'b0, cur.den}) : shifted[PROD_W-1:0];
        nxt.quo = {cur.quo[QUO_W-2:0], fits};
        return nxt;
    endfunction

    logic      valid_reg [QUO_W];
    div_item_t item_reg  [QUO_W];

    // One quotient bit per stage, most significant first.
    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic      prev_valid;
        div_item_t prev_item;

        if (k == 0) begin : g_first
            assign prev_valid = in_valid;
            assign prev_item  = in_item;
        end else begin : g_next
            assign prev_valid = valid_reg[k-1];
            assign prev_item  = item_reg[k-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (adv) begin
                valid_reg[k] <= prev_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                item_reg[k] <= div_step(prev_item);
            end
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign out_item  = item_reg[QUO_W-1];

endmodule

`default_nettype wire

[design/rsrc_out.sv]
`timescale 1ns / 1ps
`default_nettype none

module rsrc_out
    import rsrc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    input  div_item_t                 in_item,
    output logic                      adv,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_DATA_W-1:0]       m_tdata
);

    logic [QUO_W:0]         q_inc;
    logic [QUO_W-1:0]       q_round;
    logic [RATIO_W-1:0]     ratio_next;
    logic [M_DATA_W-1:0]    word_next;

    // Rounding: floor((N*2^17 + D) / 2D) equals (floor(N*2^17 / D) + 1) / 2.
    always_comb begin
        q_inc   = {1'b0, in_item.quo} + {{QUO_W{1'b0}}, 1'b1};
        q_round = q_inc[QUO_W:1];
        if (in_item.fault != FAULT_NONE) begin
            ratio_next = RATIO_ZERO;
        end else if (in_item.force_lo) begin
            ratio_next = RATIO_MIN;
        end else if (in_item.force_hi || q_round[QUO_W-1]) begin
            ratio_next = RATIO_MAX;
        end else begin
            // Subtracting 32768 from a value below 65536 flips the top bit.
            ratio_next = {~q_round[RATIO_W-1], q_round[RATIO_W-2:0]};
        end
        word_next = {{(M_DATA_W - RATIO_W - CODE_W){1'b0}}, in_item.fault, ratio_next};
    end

    // Output register with a skid word behind it.
    logic                   out_valid_reg;
    logic [M_DATA_W-1:0]    out_data_reg;
    logic                   skid_valid_reg;
    logic [M_DATA_W-1:0]    skid_data_reg;
    logic                   in_fire;

    assign adv     = !skid_valid_reg;
    assign in_fire = adv && in_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= in_fire;
            end
        end else if (in_fire) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : word_next;
        end
        if (out_valid_reg && !m_tready && in_fire) begin
            skid_data_reg <= word_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

[design/redundant_sensor_ratio_check.sv]
// Plausibility check and ratio mapping for one axis of redundant position sensors.
//
// Input stream (s_*): one word per sample set. s_tuser carries the axis select and
// the acquisition-failure flag, s_tdata the six millivolt readings.
// Output stream (m_*): one word per input word, in order: a signed Q1.15 ratio and
// a fault code (0 ok, 1 read failed, 2 low supply, 3 master sum, 4 slave sum,
// 5 bad limits); the ratio is zero whenever the fault code is not zero.
// Configuration: cfg_valid/cfg_index/cfg_data write the six limit registers; the
// port is always ready, and registers should only be changed while no word is in
// flight.
// From input acceptance to m_tvalid a word passes four check and product stages,
// seventeen divider stages (one quotient bit each) and the output register.
// Throughput is one word per clock cycle while the skid register is empty.
// Synchronous reset (aresetn low) empties the pipeline and restores the register
// defaults. When the receiver stalls, one further word is caught in a skid
// register and s_tready then falls until the output drains; nothing is dropped.

`timescale 1ns / 1ps
`default_nettype none

module redundant_sensor_ratio_check
    import rsrc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [14:0] master_a_mv, [29:15] master_b_mv, [44:30] slave_a_mv,
    // [59:45] slave_b_mv, [74:60] master_supply_mv, [89:75] slave_supply_mv, rest zero
    input  wire logic [S_DATA_W-1:0]   s_tdata,
    // [0] cmd, [1] read_failed
    input  wire logic [S_USER_W-1:0]   s_tuser,

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [15:0] axis_ratio, [18:16] fault_code, [23:19] zero
    output logic [M_DATA_W-1:0]        m_tdata,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [IDX_W-1:0]      cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data
);

    cfg_regs_t  cfg;
    in_item_t   in_item;
    logic       adv;
    logic       front_valid;
    div_item_t  front_item;
    logic       div_valid;
    div_item_t  div_item;

    assign cfg_ready = 1'b1;
    assign s_tready  = adv;

    // Unpack the input word.
    always_comb begin
        in_item.cmd              = s_tuser[0];
        in_item.read_failed      = s_tuser[1];
        in_item.master_a_mv      = s_tdata[14:0];
        in_item.master_b_mv      = s_tdata[29:15];
        in_item.slave_a_mv       = s_tdata[44:30];
        in_item.slave_b_mv       = s_tdata[59:45];
        in_item.master_supply_mv = s_tdata[74:60];
        in_item.slave_supply_mv  = s_tdata[89:75];
    end

    rsrc_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .regs     (cfg)
    );

    rsrc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .in_item   (in_item),
        .cfg       (cfg),
        .out_valid (front_valid),
        .out_item  (front_item)
    );

    rsrc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (front_valid),
        .in_item   (front_item),
        .out_valid (div_valid),
        .out_item  (div_item)
    );

    rsrc_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (div_valid),
        .in_item  (div_item),
        .adv      (adv),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

[design/rsrc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module rsrc_checker
    import rsrc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [M_DATA_W-1:0]  m_tdata
);

    // Reset empties the output.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // A faulted word carries a zero ratio.
    a_fault_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[18:16] != FAULT_NONE)) |-> (m_tdata[15:0] == RATIO_ZERO))
        else $error("faulted word with non-zero ratio");

    // Fault codes stay within the defined set and the padding is zero.
    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[18:16] <= FAULT_LIMITS) && (m_tdata[23:19] == '0)))
        else $error("undefined fault code or non-zero padding");

    // A stalled word holds.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("output word changed under stall");

endmodule

bind redundant_sensor_ratio_check rsrc_checker u_rsrc_checker (.*);

`default_nettype wire
